/* hw/rtl/pzds_pkg.sv */
// types, codes and microcode program of the point z-buffer depth splat
package pzds_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CW = 9;   // frame register width
  localparam int QW = 9;   // quotient bits kept, enough for any frame register value
  localparam int DEPTH_W = 31;

  localparam logic [8:0] FRAME_WIDTH_RST  = 9'd228;
  localparam logic [8:0] FRAME_HEIGHT_RST = 9'd185;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_SPLAT   = 2'd0,
    ST_DEPTH   = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_RADDR   = 4'd1,
    OP_RDATA   = 4'd2,
    OP_DIVINIT = 4'd3,
    OP_DIVSTEP = 4'd4,
    OP_RANGE   = 4'd5,
    OP_NADDR   = 4'd6,
    OP_NWRITE  = 4'd7,
    OP_OUT     = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_IN      = 3'd2,
    C_SPLAT_ITEM = 3'd3,
    C_SETUP_DROP = 3'd4,
    C_DIV_MORE   = 3'd5,
    C_RANGE_BAD  = 3'd6,
    C_NB_MORE    = 3'd7
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_DISPATCH = 4'd1;
  localparam step_t STEP_RADDR    = 4'd2;
  localparam step_t STEP_RDATA    = 4'd3;
  localparam step_t STEP_SETUP    = 4'd4;
  localparam step_t STEP_DIV      = 4'd5;
  localparam step_t STEP_RANGE    = 4'd6;
  localparam step_t STEP_NADDR    = 4'd7;
  localparam step_t STEP_NWRITE   = 4'd8;
  localparam step_t STEP_OUT      = 4'd9;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t cw;
    unique case (pc)
      STEP_IDLE:     cw = '{OP_NOP,     C_NO_IN,      STEP_IDLE};
      STEP_DISPATCH: cw = '{OP_NOP,     C_SPLAT_ITEM, STEP_SETUP};
      STEP_RADDR:    cw = '{OP_RADDR,   C_NEVER,      STEP_IDLE};
      STEP_RDATA:    cw = '{OP_RDATA,   C_ALWAYS,     STEP_OUT};
      STEP_SETUP:    cw = '{OP_DIVINIT, C_SETUP_DROP, STEP_OUT};
      STEP_DIV:      cw = '{OP_DIVSTEP, C_DIV_MORE,   STEP_DIV};
      STEP_RANGE:    cw = '{OP_RANGE,   C_RANGE_BAD,  STEP_OUT};
      STEP_NADDR:    cw = '{OP_NADDR,   C_NEVER,      STEP_IDLE};
      STEP_NWRITE:   cw = '{OP_NWRITE,  C_NB_MORE,    STEP_NADDR};
      STEP_OUT:      cw = '{OP_OUT,     C_ALWAYS,     STEP_IDLE};
      default:       cw = '{OP_NOP,     C_ALWAYS,     STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

/* hw/rtl/point_zbuffer_depth_splat.sv */
// point z-buffer depth splat: microcoded sequencer, divider lanes and depth store
// splat inside the frame: the result follows 9 restoring divide steps, then 9
//   read-modify-write store accesses, an address step and a write step each
// items dropped at setup or found outside at the range check skip the store walk; input
//   ready returns as the result is shown; the output step holds while one waits
// reset: frame registers to 228 x 185, then a clearing pass of MAX_WIDTH*MAX_HEIGHT
//   cells (65536 by default) zeroes the store while input ready stays low
module point_zbuffer_depth_splat import pzds_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [CW-1:0]       cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic [7:0]          read_row,
  input  logic [7:0]          read_col,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [DEPTH_W-1:0]  depth
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  // configuration
  logic [CW-1:0] frame_width;
  logic [CW-1:0] frame_height;
  logic [CW-1:0] eff_w;
  logic [CW-1:0] eff_h;

  // sequencer
  step_t pc;
  step_t pc_next;
  ctrl_t cw;
  logic  cond_hit;
  logic  in_fire;
  logic  out_busy;

  // clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // captured item
  logic               func_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic signed [31:0] z_q;
  logic [7:0]         rrow_q;
  logic [7:0]         rcol_q;

  // divider lanes
  logic [31:0] ax;
  logic [31:0] ay;
  logic [33:0] num_x;
  logic [33:0] num_y;
  logic [31:0] dd;
  logic [40:0] lim;
  logic        ovf_x;
  logic        ovf_y;
  logic        setup_drop;
  logic [40:0] rx;
  logic [40:0] ry;
  logic [40:0] dsh;
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;
  logic [3:0]  div_cnt;
  logic        ge_x;
  logic        ge_y;
  logic        range_bad;

  // neighbor walk and store access
  logic [1:0]        nb_r;
  logic [1:0]        nb_c;
  logic [10:0]       nr;
  logic [10:0]       nc;
  logic [9:0]        sel_r;
  logic [9:0]        sel_c;
  logic              sel_ok;
  logic [31:0]       addr_full;
  logic [AW-1:0]     cell_addr;
  logic              cell_ok;
  logic              keep;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DEPTH_W-1:0] ram_wdata;
  logic [DEPTH_W-1:0] ram_rdata;

  // result work registers
  logic [1:0]         st_w;
  logic [DEPTH_W-1:0] dep_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w = (32'(frame_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : frame_width;
  assign eff_h = (32'(frame_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : frame_height;

  // sequencer
  assign cw       = ucode(pc);
  assign in_ready = (pc == STEP_IDLE) && !clr_busy;
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  always_comb begin
    unique case (cw.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_NO_IN:      cond_hit = !in_fire;
      C_SPLAT_ITEM: cond_hit = !func_q;
      C_SETUP_DROP: cond_hit = setup_drop;
      C_DIV_MORE:   cond_hit = (div_cnt != 4'd0);
      C_RANGE_BAD:  cond_hit = range_bad;
      C_NB_MORE:    cond_hit = !((nb_r == 2'd2) && (nb_c == 2'd2));
      default:      cond_hit = 1'b0;
    endcase
    if (cw.op == OP_OUT && out_busy) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= STEP_IDLE;
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else begin
      pc <= pc_next;
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(CELLS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
    end
  end

  // divider setup: round(n/z) = floor((2|n| + z) / 2z), quotient kept below 2^QW
  assign ax    = x_q[31] ? (~x_q + 32'd1) : x_q;
  assign ay    = y_q[31] ? (~y_q + 32'd1) : y_q;
  assign num_x = {1'b0, ax, 1'b0} + {2'b00, z_q};
  assign num_y = {1'b0, ay, 1'b0} + {2'b00, z_q};
  assign dd    = {z_q[30:0], 1'b0};
  assign lim   = {dd, {QW{1'b0}}};
  assign ovf_x = {7'b0, num_x} >= lim;
  assign ovf_y = {7'b0, num_y} >= lim;
  assign setup_drop = z_q[31] || (z_q == 32'sd0) || ovf_x || ovf_y;

  assign ge_x = rx >= dsh;
  assign ge_y = ry >= dsh;

  assign range_bad = (x_q[31] && qx != '0) || (qx >= eff_w)
                  || (y_q[31] && qy != '0) || (qy >= eff_h);

  // neighbor coordinates, wrap to a set top bit when below zero
  assign nr = {2'b00, qy} + {9'b0, nb_r} - 11'd1;
  assign nc = {2'b00, qx} + {9'b0, nb_c} - 11'd1;

  always_comb begin
    if (cw.op == OP_RADDR) begin
      sel_r  = {2'b00, rrow_q};
      sel_c  = {2'b00, rcol_q};
      sel_ok = ({1'b0, rrow_q} < eff_h) && ({1'b0, rcol_q} < eff_w);
    end else begin
      sel_r  = nr[9:0];
      sel_c  = nc[9:0];
      sel_ok = !nr[10] && !nc[10] && (nr[9:0] < {1'b0, eff_h})
               && (nc[9:0] < {1'b0, eff_w});
    end
  end

  assign addr_full = 32'(sel_r) * 32'(MAX_WIDTH) + 32'(sel_c);

  assign keep = (ram_rdata == '0) || (z_q[DEPTH_W-1:0] < ram_rdata);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = z_q[DEPTH_W-1:0];
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (cw.op == OP_RDATA) begin
      ram_we    = cell_ok;
      ram_wdata = '0;
    end else if (cw.op == OP_NWRITE) begin
      ram_we    = cell_ok && keep;
    end
  end

  pzds_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_q <= func;
      x_q    <= point_x;
      y_q    <= point_y;
      z_q    <= point_z;
      rrow_q <= read_row;
      rcol_q <= read_col;
    end
    unique case (cw.op)
      OP_RADDR: begin
        cell_addr <= addr_full[AW-1:0];
        cell_ok   <= sel_ok;
      end
      OP_RDATA: begin
        st_w  <= ST_READ;
        dep_w <= cell_ok ? ram_rdata : '0;
      end
      OP_DIVINIT: begin
        dep_w   <= '0;
        rx      <= {7'b0, num_x};
        ry      <= {7'b0, num_y};
        dsh     <= {1'b0, dd, {(QW - 1){1'b0}}};
        div_cnt <= 4'(QW - 1);
        qx      <= '0;
        qy      <= '0;
        if (z_q[31] || z_q == 32'sd0) begin
          st_w <= ST_DEPTH;
        end else if (ovf_x || ovf_y) begin
          st_w <= ST_OUTSIDE;
        end else begin
          st_w <= ST_SPLAT;
        end
      end
      OP_DIVSTEP: begin
        if (ge_x) begin
          rx <= rx - dsh;
        end
        if (ge_y) begin
          ry <= ry - dsh;
        end
        qx      <= {qx[QW-2:0], ge_x};
        qy      <= {qy[QW-2:0], ge_y};
        dsh     <= dsh >> 1;
        if (div_cnt != 4'd0) begin
          div_cnt <= div_cnt - 4'd1;
        end
      end
      OP_RANGE: begin
        nb_r <= 2'd0;
        nb_c <= 2'd0;
        if (range_bad) begin
          st_w <= ST_OUTSIDE;
        end
      end
      OP_NADDR: begin
        cell_addr <= addr_full[AW-1:0];
        cell_ok   <= sel_ok;
      end
      OP_NWRITE: begin
        if (nb_c == 2'd2) begin
          nb_c <= 2'd0;
          nb_r <= nb_r + 2'd1;
        end else begin
          nb_c <= nb_c + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_OUT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_OUT && !out_busy) begin
      status <= st_w;
      depth  <= dep_w;
    end
  end

  // checks
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("input taken during clearing pass");

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= STEP_OUT)
    else $error("step counter left the program");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_RANGE) |-> (div_cnt == 4'd0))
    else $error("range check before divide finished");

  a_splat_nonzero: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clr_busy && pc == STEP_NWRITE) |-> (ram_wdata != '0))
    else $error("splat wrote an empty depth");

  a_out_after_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == STEP_OUT))
    else $error("result shown outside output step");

endmodule

/* hw/rtl/pzds_ram.sv */
// generic single write port, single read port ram with registered read
module pzds_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
